@@ rtl/npp_pkg.sv @@
package npp_pkg;

    localparam int IdW      = 32;
    localparam int CoordW   = 24;
    localparam int RadW     = 16;
    localparam int DiffW    = CoordW + 1;
    localparam int SqW      = 2 * DiffW;
    localparam int DistW    = SqW + 1;
    localparam int RadSqW   = 2 * RadW;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 32;

    typedef struct packed {
        logic [IdW-1:0]           entity_id;
        logic signed [CoordW-1:0] entity_x;
        logic signed [CoordW-1:0] entity_y;
        logic [RadW-1:0]          pick_radius;
        logic                     last_entity;
    } entity_t;

    typedef struct packed {
        logic [IdW-1:0] picked_id;
        logic           found;
    } pick_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_QUERY_X    = 4'd0,
        REG_QUERY_Y    = 4'd1,
        REG_MIN_RADIUS = 4'd2,
        REG_INVALID_ID = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CoordW-1:0] query_x;
        logic signed [CoordW-1:0] query_y;
        logic [RadW-1:0]          min_radius;
        logic [IdW-1:0]           invalid_id;
    } cfg_t;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [DistW-1:0] dist_sq;
        logic             hit;
        logic             last;
    } task_t;

endpackage

@@ rtl/npp_front.sv @@
module npp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             entity_valid,
    output logic             entity_ready,
    input  npp_pkg::entity_t entity,
    input  npp_pkg::cfg_t    cfg,
    output logic             push_valid,
    input  logic             push_ready,
    output npp_pkg::task_t   push_word
);
    import npp_pkg::*;

    logic                    advance;
    logic                    s1_valid_reg;
    logic signed [DiffW-1:0] s1_dx_reg;
    logic signed [DiffW-1:0] s1_dy_reg;
    logic [RadW-1:0]         s1_r_reg;
    logic [IdW-1:0]          s1_id_reg;
    logic                    s1_skip_reg;
    logic                    s1_last_reg;
    logic                    s2_valid_reg;
    logic [SqW-1:0]          s2_dxsq_reg;
    logic [SqW-1:0]          s2_dysq_reg;
    logic [RadSqW-1:0]       s2_rsq_reg;
    logic [IdW-1:0]          s2_id_reg;
    logic                    s2_skip_reg;
    logic                    s2_last_reg;
    logic signed [DiffW-1:0] dx_next;
    logic signed [DiffW-1:0] dy_next;
    logic [RadW-1:0]         r_next;
    logic signed [SqW-1:0]   dxsq_next;
    logic signed [SqW-1:0]   dysq_next;
    logic [DistW-1:0]        dist_sq;
    logic                    hit;

    assign dx_next   = DiffW'(entity.entity_x) - DiffW'(cfg.query_x);
    assign dy_next   = DiffW'(entity.entity_y) - DiffW'(cfg.query_y);
    assign r_next    = (entity.pick_radius > cfg.min_radius) ? entity.pick_radius
                                                             : cfg.min_radius;
    assign dxsq_next = s1_dx_reg * s1_dx_reg;
    assign dysq_next = s1_dy_reg * s1_dy_reg;

    assign dist_sq = {1'b0, s2_dxsq_reg} + {1'b0, s2_dysq_reg};
    assign hit     = !s2_skip_reg && (dist_sq <= {{(DistW-RadSqW){1'b0}}, s2_rsq_reg});

    assign push_valid = s2_valid_reg && (hit || s2_last_reg);
    assign push_word  = '{id: s2_id_reg, dist_sq: dist_sq, hit: hit, last: s2_last_reg};

    assign advance      = !(push_valid && !push_ready);
    assign entity_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= entity_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_dx_reg   <= dx_next;
            s1_dy_reg   <= dy_next;
            s1_r_reg    <= r_next;
            s1_id_reg   <= entity.entity_id;
            s1_skip_reg <= (entity.entity_id == cfg.invalid_id);
            s1_last_reg <= entity.last_entity;
            s2_dxsq_reg <= SqW'(dxsq_next);
            s2_dysq_reg <= SqW'(dysq_next);
            s2_rsq_reg  <= s1_r_reg * s1_r_reg;
            s2_id_reg   <= s1_id_reg;
            s2_skip_reg <= s1_skip_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

endmodule

@@ rtl/npp_queue.sv @@
module npp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  npp_pkg::task_t push_word,
    output logic           pop_valid,
    input  logic           pop_ready,
    output npp_pkg::task_t pop_word
);
    import npp_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    task_t           slot_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ rtl/npp_back.sv @@
module npp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  npp_pkg::task_t pop_word,
    input  logic [npp_pkg::IdW-1:0] invalid_id,
    output logic           pick_valid,
    input  logic           pick_ready,
    output npp_pkg::pick_t pick
);
    import npp_pkg::*;

    logic             have_best_reg;
    logic [IdW-1:0]   best_id_reg;
    logic [DistW-1:0] best_dist_reg;
    logic             out_valid_reg;
    pick_t            out_reg;
    logic             do_pop;
    logic             take;

    assign pop_ready  = !pop_word.last || !out_valid_reg || pick_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign take       = pop_word.hit && (!have_best_reg || (pop_word.dist_sq < best_dist_reg));
    assign pick_valid = out_valid_reg;
    assign pick       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop && pop_word.last)
            begin
                have_best_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (do_pop && take)
                begin
                    have_best_reg <= 1'b1;
                end
                if (pick_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && take)
        begin
            best_id_reg   <= pop_word.id;
            best_dist_reg <= pop_word.dist_sq;
        end
        if (do_pop && pop_word.last)
        begin
            out_reg.found     <= take || have_best_reg;
            out_reg.picked_id <= take ? pop_word.id
                               : (have_best_reg ? best_id_reg : invalid_id);
        end
    end

endmodule

@@ rtl/nearest_point_pick.sv @@
// channel  | direction | handshake                  | word
// ---------+-----------+----------------------------+------------------------------
// entity   | in        | entity_valid / entity_ready | npp_pkg::entity_t
// pick     | out       | pick_valid / pick_ready     | npp_pkg::pick_t
// cfg      | in        | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One entity word per cycle while entity_ready is high; a pick word leaves via the
// difference, square, queue and output registers. The only feedback is the 51-bit
// nearest-distance compare in the back end. Reset clears all control state and
// the query registers. A stalled pick output fills the queue, then drops entity_ready.
module nearest_point_pick #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         entity_valid,
    output logic                         entity_ready,
    input  npp_pkg::entity_t             entity,
    output logic                         pick_valid,
    input  logic                         pick_ready,
    output npp_pkg::pick_t               pick,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [npp_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [npp_pkg::CfgDataW-1:0] cfg_data
);
    import npp_pkg::*;

    cfg_t  cfg_reg;
    logic  push_valid;
    logic  push_ready;
    task_t push_word;
    logic  pop_valid;
    logic  pop_ready;
    task_t pop_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUERY_X:    cfg_reg.query_x    <= cfg_data[CoordW-1:0];
                REG_QUERY_Y:    cfg_reg.query_y    <= cfg_data[CoordW-1:0];
                REG_MIN_RADIUS: cfg_reg.min_radius <= cfg_data[RadW-1:0];
                REG_INVALID_ID: cfg_reg.invalid_id <= cfg_data[IdW-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    npp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .entity_valid (entity_valid),
        .entity_ready (entity_ready),
        .entity       (entity),
        .cfg          (cfg_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_word    (push_word)
    );

    npp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    npp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word),
        .invalid_id (cfg_reg.invalid_id),
        .pick_valid (pick_valid),
        .pick_ready (pick_ready),
        .pick       (pick)
    );

endmodule

@@ tb/sv/nearest_point_pick_test.sv @@
`timescale 1ns / 100ps

module nearest_point_pick_test;
    import npp_pkg::*;

    localparam int CoordHi      = (1 << (CoordW - 1)) - 1;
    localparam int CoordLo      = -(1 << (CoordW - 1));
    localparam int RegCount     = REG_INVALID_ID + 1;
    localparam int CfgSlots     = 1 << CfgIdxW;
    localparam int RadMax       = (1 << RadW) - 1;
    localparam int DrainCycles  = 8;
    localparam int HoldCycles   = 400;
    localparam int RandomItems  = 850;
    localparam int ReportLimit  = 10;

    class nearest_hit_tracker;
        cfg_t             cfg;
        logic [IdW-1:0]   best_id;
        logic [DistW-1:0] best_dist;
        bit               have_best;
        pick_t            due_picks[$];
        int               mismatch_count;

        function new();
            cfg            = '0;
            best_id        = '0;
            best_dist      = '0;
            have_best      = 1'b0;
            mismatch_count = 0;
        endfunction

        function void take_config(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                REG_QUERY_X:    cfg.query_x    = data[CoordW-1:0];
                REG_QUERY_Y:    cfg.query_y    = data[CoordW-1:0];
                REG_MIN_RADIUS: cfg.min_radius = data[RadW-1:0];
                REG_INVALID_ID: cfg.invalid_id = data[IdW-1:0];
                default: ;
            endcase
        endfunction

        function void take_entity(entity_t e);
            longint          dx;
            longint          dy;
            longint          dist_sq;
            longint          reach_sq;
            logic [RadW-1:0] reach;
            pick_t           p;
            if (e.entity_id != cfg.invalid_id)
            begin
                dx = longint'($signed(e.entity_x)) - longint'($signed(cfg.query_x));
                dy = longint'($signed(e.entity_y)) - longint'($signed(cfg.query_y));
                dist_sq = dx * dx + dy * dy;
                reach = (e.pick_radius > cfg.min_radius) ? e.pick_radius : cfg.min_radius;
                reach_sq = longint'(reach) * longint'(reach);
                if (dist_sq <= reach_sq && (!have_best || DistW'(dist_sq) < best_dist))
                begin
                    best_id   = e.entity_id;
                    best_dist = DistW'(dist_sq);
                    have_best = 1'b1;
                end
            end
            if (e.last_entity)
            begin
                p.picked_id = have_best ? best_id : cfg.invalid_id;
                p.found     = have_best;
                due_picks   = {due_picks, p};
                best_id   = cfg.invalid_id;
                best_dist = '0;
                have_best = 1'b0;
            end
        endfunction

        function void match_pick(pick_t got);
            pick_t want;
            if (due_picks.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit)
                    $display("%0t: pick word with none due: id %h found %b",
                             $realtime, got.picked_id, got.found);
                return;
            end
            want = due_picks.pop_front();
            if (got.picked_id !== want.picked_id || got.found !== want.found)
            begin
                mismatch_count++;
                if (mismatch_count <= ReportLimit)
                    $display("%0t: pick mismatch: expected id %h found %b, got id %h found %b",
                             $realtime, want.picked_id, want.found, got.picked_id, got.found);
            end
        endfunction

        function int pending();
            return due_picks.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                entity_valid;
    logic                entity_ready;
    entity_t             entity;
    logic                pick_valid;
    logic                pick_ready;
    pick_t               pick;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    nearest_hit_tracker  board;
    bit                  steady;
    bit                  hold_request;
    int                  sent;
    logic signed [CoordW-1:0] prev_x;
    logic signed [CoordW-1:0] prev_y;

    nearest_point_pick dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .entity_valid (entity_valid),
        .entity_ready (entity_ready),
        .entity       (entity),
        .pick_valid   (pick_valid),
        .pick_ready   (pick_ready),
        .pick         (pick),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    function int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function entity_t make_entity(logic [IdW-1:0] id, int x, int y, int r, bit last);
        entity_t e;
        e.entity_id   = id;
        e.entity_x    = CoordW'(x);
        e.entity_y    = CoordW'(y);
        e.pick_radius = RadW'(r);
        e.last_entity = last;
        return e;
    endfunction

    function int pick_coord_extreme();
        case ($urandom_range(0, 2))
            0: return CoordLo;
            1: return CoordHi;
            default: return 0;
        endcase
    endfunction

    function entity_t random_entity(bit last);
        entity_t e;
        int      roll;
        int      span;
        int      r;
        roll = $urandom_range(0, 99);
        e.entity_id = (roll < 15) ? board.cfg.invalid_id : $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            e.entity_x = prev_x;
            e.entity_y = prev_y;
        end
        else if (roll < 65)
        begin
            case ($urandom_range(0, 2))
                0: span = 'h40;
                1: span = 'h400;
                default: span = 'h4000;
            endcase
            e.entity_x = CoordW'(int'($signed(board.cfg.query_x)) +
                                 int'($urandom_range(0, 2 * span)) - span);
            e.entity_y = CoordW'(int'($signed(board.cfg.query_y)) +
                                 int'($urandom_range(0, 2 * span)) - span);
        end
        else if (roll < 90)
        begin
            e.entity_x = CoordW'($urandom);
            e.entity_y = CoordW'($urandom);
        end
        else
        begin
            e.entity_x = CoordW'(pick_coord_extreme());
            e.entity_y = CoordW'(pick_coord_extreme());
        end
        case ($urandom_range(0, 3))
            0: r = 0;
            1: r = $urandom_range(0, 'h800);
            2: r = $urandom_range(0, RadMax);
            default: r = RadMax;
        endcase
        e.pick_radius = RadW'(r);
        e.last_entity = last;
        prev_x = e.entity_x;
        prev_y = e.entity_y;
        return e;
    endfunction

    task drive_entity(input entity_t e);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0)
        begin
            entity_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        entity       <= e;
        entity_valid <= 1'b1;
        do
            @(posedge clk);
        while (!entity_ready);
        board.take_entity(e);
        sent++;
        @(negedge clk);
    endtask

    task write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.take_config(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task drain();
        entity_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        @(negedge clk);
    endtask

    task random_config();
        int roll;
        if ($urandom_range(0, 1))
        begin
            roll = $urandom_range(0, 7);
            write_cfg(REG_QUERY_X, roll == 0 ? CoordHi : roll == 1 ? CoordLo : $urandom);
        end
        if ($urandom_range(0, 1))
        begin
            roll = $urandom_range(0, 7);
            write_cfg(REG_QUERY_Y, roll == 0 ? CoordHi : roll == 1 ? CoordLo : $urandom);
        end
        if ($urandom_range(0, 1))
        begin
            roll = $urandom_range(0, 7);
            write_cfg(REG_MIN_RADIUS, roll < 2 ? 0 : roll == 2 ? RadMax :
                      roll == 3 ? $urandom : $urandom_range(0, 'h800));
        end
        if ($urandom_range(0, 1))
            write_cfg(REG_INVALID_ID, $urandom_range(0, 2) == 0 ? $urandom_range(0, 15) :
                      $urandom);
        if ($urandom_range(0, 5) == 0)
            write_cfg(CfgIdxW'($urandom_range(RegCount, CfgSlots - 1)), $urandom);
    endtask

    // drain the pick output with random stalls, calm stretches and one long hold
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        pick_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                pick_ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                pick_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                pick_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) == 0)
                    calm_left = $urandom_range(50, 150);
                else if ($urandom_range(0, 2) == 0)
                    stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pick_valid && pick_ready)
            board.match_pick(pick);
    end

    initial
    begin
        int  pick_left;
        int  phase_len;
        int  roll;
        bit  first_phase;
        board        = new();
        rst_n        = 1'b0;
        entity_valid = 1'b0;
        entity       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        sent         = 0;
        prev_x       = '0;
        prev_y       = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: invalid last entity, exact hit at the origin
        drive_entity(make_entity(0, 0, 0, 0, 1'b1));
        drive_entity(make_entity(5, 0, 0, 0, 1'b1));
        drain();

        // query at opposite corners, widest radius, all-ones invalid id
        write_cfg(REG_QUERY_X, CoordHi);
        write_cfg(REG_QUERY_Y, 32'hFF80_0000);
        write_cfg(REG_MIN_RADIUS, RadMax);
        write_cfg(REG_INVALID_ID, 32'hFFFF_FFFF);
        drive_entity(make_entity(0, CoordLo, CoordHi, RadMax, 1'b0));
        drive_entity(make_entity(1, CoordHi, CoordLo, 0, 1'b0));
        drive_entity(make_entity(2, CoordHi, CoordLo, RadMax, 1'b0));
        drive_entity(make_entity(32'hFFFF_FFFF, CoordHi, CoordLo, 0, 1'b1));
        drain();

        // radius boundary, own radius above the minimum, nearer hit replaces
        write_cfg(REG_QUERY_X, 0);
        write_cfg(REG_QUERY_Y, 32'hAB00_0000);
        write_cfg(REG_MIN_RADIUS, 'h100);
        write_cfg(REG_INVALID_ID, 7);
        write_cfg(CfgIdxW'(CfgSlots - 1), $urandom);
        drive_entity(make_entity(10, 'h100, 0, 0, 1'b0));
        drive_entity(make_entity(11, 'h101, 0, 0, 1'b0));
        drive_entity(make_entity(12, 0, -'h80, 0, 1'b0));
        drive_entity(make_entity(13, 'h200, 'h200, 'h300, 1'b1));

        // invalid id changed while a hit is held, then while nothing is held
        drive_entity(make_entity(9, 0, 0, 0, 1'b0));
        drain();
        write_cfg(REG_INVALID_ID, 9);
        drive_entity(make_entity(3, CoordHi, CoordHi, 0, 1'b1));
        drive_entity(make_entity(4, 'h400, 0, 0, 1'b0));
        drain();
        write_cfg(REG_INVALID_ID, 'h1234);
        drive_entity(make_entity(5, 'h400, 0, 0, 1'b1));
        drive_entity(make_entity(0, CoordLo, CoordLo, 0, 1'b1));

        sent        = 0;
        pick_left   = 0;
        first_phase = 1'b1;
        while (sent < RandomItems)
        begin
            drain();
            random_config();
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(30, 90);
            if (first_phase)
            begin
                steady       = 1'b1;
                hold_request = 1'b1;
                first_phase  = 1'b0;
            end
            repeat (phase_len)
            begin
                if (pick_left == 0)
                begin
                    roll = $urandom_range(0, 99);
                    pick_left = roll < 70 ? $urandom_range(1, 4) :
                                roll < 95 ? $urandom_range(5, 12) : $urandom_range(13, 30);
                end
                drive_entity(random_entity(pick_left == 1));
                pick_left--;
            end
        end

        entity_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
